/* rtl/ccw_pkg.sv */
// Shared constants, codes and types for the text console character writer.
// No dependencies; compiled first.
package ccw_pkg;

	// default geometry of the console
	localparam int COLS_DEF     = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 4;

	// fixed item field widths
	localparam int ACTION_W = 1;
	localparam int CHAR_W   = 8;
	localparam int CADDR_W  = 11;
	localparam int CURSOR_W = 11;
	localparam int CELL_W   = 16;

	// attribute register value after reset
	localparam logic [CHAR_W-1:0] ATTR_RST = 8'h03;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_WRITE = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 1'b1;

	// special byte codes
	localparam logic [CHAR_W-1:0] KEY_ESC   = 8'h1B;
	localparam logic [CHAR_W-1:0] KEY_END   = 8'h6D;
	localparam logic [CHAR_W-1:0] KEY_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] KEY_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] KEY_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] KEY_SPACE = 8'h20;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRAP,
		ST_CHECK,
		ST_PUT,
		ST_COPY,
		ST_BLANK,
		ST_DONE
	} state_t;

	// operand selection of the shared address adder
	typedef enum logic [1:0] {
		ALU_CURSOR,
		ALU_STRIDE,
		ALU_COPY
	} alu_op_t;

endpackage

/* rtl/ccw_if.sv */
// Valid/ready channel interfaces for console request and response items.
// Depends on ccw_pkg for the field widths.
interface ccw_req_if import ccw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CHAR_W-1:0]   char_code;
	logic [CADDR_W-1:0]  cell_address;

	modport source (output valid, output action, output char_code, output cell_address,
		input ready);
	modport sink (input valid, input action, input char_code, input cell_address,
		output ready);
endinterface

interface ccw_rsp_if import ccw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CURSOR_W-1:0] cursor_pos;
	logic [CELL_W-1:0]   cell_data;
	logic                escape_active;

	modport source (output valid, output cursor_pos, output cell_data, output escape_active,
		input ready);
	modport sink (input valid, input cursor_pos, input cell_data, input escape_active,
		output ready);
endinterface

/* rtl/ccw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccw_ram #(
	parameter int  WIDTH = 16,
	parameter int  DEPTH = 2000,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/ccw_alu.sv */
// Shared address adder: cursor cell address, next row base, scroll source address.
// Depends on ccw_pkg for the operation codes.
module ccw_alu import ccw_pkg::*; #(
	parameter int COLS   = COLS_DEF,
	parameter int CUR_W  = 11,
	parameter int COL_W  = 7,
	parameter int ADDR_W = 11
) (
	input  alu_op_t           op,
	input  logic [CUR_W-1:0]  row_base,
	input  logic [COL_W-1:0]  column,
	input  logic [ADDR_W-1:0] idx,
	output logic [CUR_W-1:0]  sum
);

	logic [CUR_W-1:0] opa;
	logic [CUR_W-1:0] opb;

	// operand selection
	always_comb begin
		unique case (op)
			ALU_CURSOR: begin
				opa = row_base;
				opb = CUR_W'(column);
			end
			ALU_STRIDE: begin
				opa = row_base;
				opb = CUR_W'(COLS);
			end
			ALU_COPY: begin
				opa = CUR_W'(idx);
				opb = CUR_W'(COLS);
			end
			default: begin
				opa = row_base;
				opb = CUR_W'(column);
			end
		endcase
	end

	// the one adder
	assign sum = opa + opb;

endmodule

/* rtl/text_console_char_writer_top.sv */
// Text console character writer: sequencer, cursor state and cell memory.
// Depends on ccw_pkg, ccw_if, ccw_ram and ccw_alu.
//
//   port          | dir  | handshake        | carries
//   req           | in   | valid/ready      | action, char_code, cell_address
//   rsp           | out  | valid/ready      | cursor_pos, cell_data, escape_active
//   cfg_wr_en/data| in   | write enable     | attribute byte
//
// A scroll copies every row but the first one row up and then clears the last row; the cell
// memory has one write port, and the copy and the clear move one cell a cycle.
// After reset a clearing pass zeroes the cells, with req.ready low.
// The result sits in an output register; the next item is taken while it waits,
// and the block stalls only when a new result is ready and the old one is not taken.
module text_console_char_writer_top import ccw_pkg::*; #(
	parameter int COLS     = COLS_DEF,
	parameter int ROWS     = ROWS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ccw_req_if.sink           req,
	ccw_rsp_if.source         rsp,
	input  logic              cfg_wr_en,
	input  logic [CHAR_W-1:0] cfg_wr_data
);

	localparam int CELLS     = COLS * ROWS;
	localparam int COPY_N    = COLS * (ROWS - 1);
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int CUR_W     = $clog2(CELLS + 1);
	localparam int COL_W     = $clog2(COLS + 1);
	localparam int ROW_W     = $clog2(ROWS + 1);
	localparam int CNT_W     = $clog2(TAB_STOP + 1);
	localparam int CMP_W     = (CUR_W > CADDR_W) ? CUR_W : CADDR_W;

	// control state
	state_t            state_q, state_d;
	logic [COL_W-1:0]  column_q;
	logic [ROW_W-1:0]  row_q;
	logic [CUR_W-1:0]  row_base_q;
	logic [CNT_W-1:0]  col_mod_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              esc_q;
	logic [CHAR_W-1:0] attr_q;
	logic              write_q;
	logic              lf_q;
	logic              tab_q;
	logic              force_q;
	logic [ADDR_W-1:0] idx_q;
	logic              wv_s1;
	logic              ovalid_q;

	// payload registers
	logic [CHAR_W-1:0]   ch_q;
	logic                rd_ok_q;
	logic [ADDR_W-1:0]   wa_s1;
	logic [CELL_W-1:0]   data_q;
	logic [CURSOR_W-1:0] ocur_q;
	logic [CELL_W-1:0]   odata_q;
	logic                oesc_q;

	// memory and adder hookup
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;
	alu_op_t           alu_op;
	logic [CUR_W-1:0]  alu_sum;

	// decoded conditions
	logic accept;
	logic skip_byte;
	logic in_range;
	logic col_full;
	logic row_over;
	logic copy_rd;
	logic idx_last;
	logic load;

	assign accept    = req.valid && req.ready;
	assign skip_byte = esc_q || (req.char_code == KEY_ESC);
	assign in_range  = CMP_W'(req.cell_address) < CMP_W'(CELLS);
	assign col_full  = column_q == COL_W'(COLS);
	assign row_over  = row_q == ROW_W'(ROWS);
	assign copy_rd   = idx_q != ADDR_W'(COPY_N);
	assign idx_last  = idx_q == ADDR_W'(CELLS - 1);
	assign load      = (state_q == ST_DONE) && (!ovalid_q || rsp.ready);

	ccw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_ccw_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ccw_alu #(
		.COLS   (COLS),
		.CUR_W  (CUR_W),
		.COL_W  (COL_W),
		.ADDR_W (ADDR_W)
	) u_ccw_alu (
		.op       (alu_op),
		.row_base (row_base_q),
		.column   (column_q),
		.idx      (idx_q),
		.sum      (alu_sum)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (idx_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.action == ACT_READ) state_d = ST_READ;
					else if (skip_byte)         state_d = ST_DONE;
					else                        state_d = ST_WRAP;
				end
			end
			ST_READ:  state_d = ST_DONE;
			ST_WRAP:  state_d = ST_CHECK;
			ST_CHECK: state_d = row_over ? ST_COPY : ST_PUT;
			ST_PUT: begin
				if (write_q)            state_d = (cnt_q == CNT_W'(1)) ? ST_DONE : ST_WRAP;
				else if (lf_q || tab_q) state_d = ST_WRAP;
				else                    state_d = ST_DONE;
			end
			ST_COPY: begin
				if (!copy_rd) state_d = ST_BLANK;
			end
			ST_BLANK: begin
				if (idx_last) state_d = ST_PUT;
			end
			ST_DONE: begin
				if (load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port and adder control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = ADDR_W'(alu_sum);
		alu_op    = ALU_CURSOR;
		unique case (state_q)
			ST_CLEAR, ST_BLANK: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				ram_re    = accept;
				ram_raddr = ADDR_W'(req.cell_address);
			end
			ST_WRAP: begin
				alu_op = ALU_STRIDE;
			end
			ST_PUT: begin
				ram_we    = write_q;
				ram_waddr = ADDR_W'(alu_sum);
				ram_wdata = {attr_q, ch_q};
			end
			ST_COPY: begin
				alu_op    = ALU_COPY;
				ram_re    = copy_rd;
				ram_we    = wv_s1;
				ram_waddr = wa_s1;
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// cursor, escape and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			column_q   <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			col_mod_q  <= '0;
			cnt_q      <= '0;
			esc_q      <= 1'b0;
			attr_q     <= ATTR_RST;
			write_q    <= 1'b0;
			lf_q       <= 1'b0;
			tab_q      <= 1'b0;
			force_q    <= 1'b0;
			idx_q      <= '0;
			wv_s1      <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			wv_s1   <= (state_q == ST_COPY) && copy_rd;
			if (cfg_wr_en) attr_q <= cfg_wr_data;
			if (load) ovalid_q <= 1'b1;
			else if (rsp.valid && rsp.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + ADDR_W'(1);
				end
				ST_IDLE: begin
					if (accept && req.action == ACT_WRITE) begin
						if (esc_q) begin
							esc_q <= req.char_code != KEY_END;
						end else if (req.char_code == KEY_ESC) begin
							esc_q <= 1'b1;
						end else begin
							write_q <= (req.char_code != KEY_LF) && (req.char_code != KEY_CR)
								&& (req.char_code != KEY_TAB);
							lf_q    <= req.char_code == KEY_LF;
							tab_q   <= req.char_code == KEY_TAB;
							force_q <= 1'b0;
							cnt_q   <= CNT_W'(1);
						end
					end
				end
				ST_WRAP: begin
					// pending wrap or forced newline
					if (force_q || col_full) begin
						column_q   <= '0;
						col_mod_q  <= '0;
						row_q      <= row_q + ROW_W'(1);
						row_base_q <= alu_sum;
					end
					force_q <= 1'b0;
				end
				ST_CHECK: begin
					idx_q <= '0;
				end
				ST_PUT: begin
					if (write_q) begin
						column_q  <= column_q + COL_W'(1);
						col_mod_q <= (col_mod_q == CNT_W'(TAB_STOP - 1)) ? '0
							: col_mod_q + CNT_W'(1);
						cnt_q     <= cnt_q - CNT_W'(1);
					end else if (lf_q) begin
						// line feed: force_q makes the wrap step start a new line
						lf_q    <= 1'b0;
						force_q <= 1'b1;
					end else if (tab_q) begin
						// spaces up to the next tab stop
						tab_q   <= 1'b0;
						write_q <= 1'b1;
						cnt_q   <= CNT_W'(TAB_STOP) - col_mod_q;
					end
				end
				ST_COPY: begin
					if (copy_rd) idx_q <= idx_q + ADDR_W'(1);
				end
				ST_BLANK: begin
					idx_q <= idx_q + ADDR_W'(1);
					if (idx_last) begin
						row_q      <= ROW_W'(ROWS - 1);
						row_base_q <= CUR_W'(COPY_N);
					end
				end
				default: begin
					force_q <= force_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		wa_s1 <= idx_q;
		if (accept) begin
			ch_q    <= req.char_code;
			rd_ok_q <= in_range;
			data_q  <= '0;
		end
		if (state_q == ST_PUT && !write_q && !lf_q && tab_q) ch_q <= KEY_SPACE;
		if (state_q == ST_READ) data_q <= rd_ok_q ? ram_rdata : '0;
		if (load) begin
			ocur_q  <= CURSOR_W'(alu_sum);
			odata_q <= data_q;
			oesc_q  <= esc_q;
		end
	end

	// channel outputs
	assign req.ready         = state_q == ST_IDLE;
	assign rsp.valid         = ovalid_q;
	assign rsp.cursor_pos    = ocur_q;
	assign rsp.cell_data     = odata_q;
	assign rsp.escape_active = oesc_q;

endmodule

/* rtl/ccw_checker.sv */
// Port-level checks for the text console character writer, bound to its top level.
// Depends on ccw_pkg and text_console_char_writer_top.
module ccw_port_assert import ccw_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [CURSOR_W-1:0] rsp_cursor_pos,
	input logic [CELL_W-1:0]   rsp_cell_data
);

	// one item at a time: busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after an item was taken");

	// a new result only shows up while the block was busy
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without work in progress");

	// cursor never runs past the parked position on the last row
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (COLS * ROWS < 2048) |-> int'(rsp_cursor_pos) <= COLS * ROWS)
		else $error("cursor position out of range");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_pos)
			&& $stable(rsp_cell_data))
		else $error("stalled result changed");

endmodule

bind text_console_char_writer_top ccw_port_assert #(
	.COLS (COLS),
	.ROWS (ROWS)
) u_ccw_port_assert (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_cursor_pos (rsp.cursor_pos),
	.rsp_cell_data  (rsp.cell_data)
);
